// File: hw/rtl/glzw_pkg.sv
// Package for the GIF LZW decoder: payload types, codes and sizes.
// No dependencies.
package glzw_pkg;
	localparam int MaxCodeBits = 12;
	localparam int Depth = 1 << MaxCodeBits;
	localparam int AddrW = MaxCodeBits;
	localparam int CntW = MaxCodeBits + 1;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_PULL = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [2:0] ST_PIXEL = 3'd0;
	localparam logic [2:0] ST_ACCEPTED = 3'd1;
	localparam logic [2:0] ST_REJECTED = 3'd2;
	localparam logic [2:0] ST_NEED_DATA = 3'd3;
	localparam logic [2:0] ST_END_IMAGE = 3'd4;
	localparam logic [2:0] ST_END_DATA = 3'd5;
	localparam logic [2:0] ST_RESTARTED = 3'd6;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic [2:0] status;
		logic       more_pending;
	} out_item_t;

	// controller -> datapath commands
	typedef struct packed {
		logic take;      // latch input item
		logic dec;       // decode the latched item (push, restart or pull)
		logic walk;      // one chain step (table read issued previous cycle)
		logic finish;    // finish chain: push root, add entry
		logic pop_rd;    // issue stack read for pop
		logic emit;      // write result to output register
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic       op_pull;
		logic       stack_empty;
		logic [2:0] dec_kind;   // what decode found
		logic       walk_more;  // chain not yet at root
	} sts_t;

	localparam logic [2:0] DK_SIMPLE = 3'd0; // result ready now
	localparam logic [2:0] DK_CLEAR = 3'd1;  // clear code consumed, decode again
	localparam logic [2:0] DK_CHAIN = 3'd2;  // chain walk needed
	localparam logic [2:0] DK_POP = 3'd3;    // stack non-empty: pop
endpackage

// File: hw/rtl/glzw_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module glzw_ram #(
	parameter int Width = 8,
	parameter int Words = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Words)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Words)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Words];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/glzw_ctrl.sv
// Controller for the GIF LZW decoder: sequences decode, chain walk and pop.
// Depends on glzw_pkg.
module glzw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           out_full,
	input  glzw_pkg::sts_t sts,
	output glzw_pkg::cmd_t cmd
);
	import glzw_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_POP = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != S_IDLE) || out_full;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !out_full) begin
					cmd.take = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				if (!sts.op_pull) begin
					state_d = S_EMIT;
				end else begin
					case (sts.dec_kind)
						DK_SIMPLE: state_d = S_EMIT;
						DK_CLEAR: state_d = S_DEC;
						DK_CHAIN: state_d = S_WALK;
						DK_POP: begin
							cmd.pop_rd = 1'b1;
							state_d = S_EMIT;
						end
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_WALK: begin
				if (sts.walk_more) begin
					cmd.walk = 1'b1;
				end else begin
					cmd.finish = 1'b1;
					state_d = S_POP;
				end
			end
			S_POP: begin
				cmd.pop_rd = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

// File: hw/rtl/glzw_dp.sv
// Datapath for the GIF LZW decoder: bit buffer, code tables, pixel stack.
// Depends on glzw_pkg and glzw_ram.
module glzw_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_data,
	input  glzw_pkg::in_item_t  in_item,
	input  glzw_pkg::cmd_t      cmd,
	output glzw_pkg::sts_t      sts,
	output glzw_pkg::out_item_t res,
	output logic                res_load
);
	import glzw_pkg::*;

	logic [3:0]       mcs_q;
	in_item_t         item_q;
	logic [CntW-1:0]  stack_cnt_q;
	logic [19:0]      acc_q;
	logic [4:0]       bits_q;
	logic [7:0]       sub_left_q;
	logic [3:0]       cw_q;
	logic [CntW-1:0]  next_free_q;
	logic [CntW-1:0]  limit_q;
	logic [AddrW-1:0] prev_q;
	logic [7:0]       first_q;
	logic             have_prev_q;
	logic             done_q;
	logic [AddrW-1:0] code_q;   // chain cursor
	logic [AddrW-1:0] in_code_q;
	logic             kw_q;     // KwKwK pending push of first char
	logic [7:0]       rpix_q;
	logic [2:0]       rst_q;
	logic             pop_q;    // stack read issued last cycle

	// effective root size and derived codes
	logic [3:0]       m_eff;
	logic [CntW-1:0]  clear_c;
	logic [AddrW-1:0] cmask;
	logic [AddrW-1:0] code_now;
	logic             bits_ok;

	always_comb begin
		m_eff = (mcs_q < 4'd2) ? 4'd2 : ((mcs_q > 4'd9) ? 4'd9 : mcs_q);
		if (m_eff > 4'(MaxCodeBits - 1)) m_eff = 4'(MaxCodeBits - 1);
		clear_c = CntW'(1) << m_eff;
		cmask = AddrW'((CntW'(1) << cw_q) - CntW'(1));
		code_now = acc_q[AddrW-1:0] & cmask;
		bits_ok = {1'b0, bits_q} >= {2'b0, cw_q};
	end

	// chain step view signals
	logic             walking_q;
	logic [AddrW-1:0] cur;
	logic             cur_more;
	logic [7:0]       tbl_root;
	logic             stk_room;
	logic             stk_room2;

	// memories
	logic             tbl_we;
	logic [AddrW-1:0] tbl_raddr;
	logic [AddrW-1:0] pre_rd;
	logic [7:0]       suf_rd;
	logic             stk_we;
	logic [AddrW-1:0] stk_waddr;
	logic [7:0]       stk_wdata;
	logic [7:0]       stk_rd;

	glzw_ram #(.Width(AddrW), .Words(Depth)) u_prefix (
		.clk(clk), .we(tbl_we), .waddr(next_free_q[AddrW-1:0]), .wdata(prev_q),
		.raddr(tbl_raddr), .rdata(pre_rd)
	);
	glzw_ram #(.Width(8), .Words(Depth)) u_suffix (
		.clk(clk), .we(tbl_we), .waddr(next_free_q[AddrW-1:0]), .wdata(tbl_root),
		.raddr(tbl_raddr), .rdata(suf_rd)
	);
	glzw_ram #(.Width(8), .Words(Depth)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(AddrW'(stack_cnt_q - CntW'(1))), .rdata(stk_rd)
	);

	// chain step view: cursor is code_q while priming, else the prefix just read
	assign cur = walking_q ? pre_rd : code_q;
	assign stk_room = stack_cnt_q < CntW'(Depth - 1);
	assign stk_room2 = stack_cnt_q < CntW'(Depth - 2);
	assign cur_more = {1'b0, cur} >= clear_c + CntW'(2);
	assign tbl_root = cur[7:0];
	assign tbl_raddr = cur;

	// decode classification
	always_comb begin
		sts.op_pull = item_q.op == OP_PULL;
		sts.stack_empty = stack_cnt_q == '0;
		sts.walk_more = kw_q || walking_q || (cur_more && stk_room);
		if (stack_cnt_q != '0) sts.dec_kind = DK_POP;
		else if (done_q || !bits_ok) sts.dec_kind = DK_SIMPLE;
		else if ({1'b0, code_now} == clear_c) sts.dec_kind = DK_CLEAR;
		else if ({1'b0, code_now} == clear_c + CntW'(1)) sts.dec_kind = DK_SIMPLE;
		else if (!have_prev_q) sts.dec_kind = DK_SIMPLE;
		else sts.dec_kind = DK_CHAIN;
	end

	// stack writes: KwKwK first char, chain suffix, or root at finish
	always_comb begin
		stk_we = 1'b0;
		stk_wdata = first_q;
		if (cmd.walk) begin
			stk_we = kw_q || walking_q;
			stk_wdata = kw_q ? first_q : suf_rd;
		end else if (cmd.finish) begin
			stk_we = 1'b1;
			stk_wdata = tbl_root;
		end
	end
	assign stk_waddr = stack_cnt_q[AddrW-1:0];
	assign tbl_we = cmd.finish && (next_free_q < CntW'(Depth));

	// result formed from the status register; popped pixels come from the stack
	always_comb begin
		res_load = cmd.emit;
		res.pixel = '0;
		res.status = rst_q;
		res.more_pending = stack_cnt_q != '0;
		if (rst_q == ST_PIXEL) res.pixel = pop_q ? stk_rd : rpix_q;
	end

	logic [19:0] acc_sh;
	assign acc_sh = acc_q >> cw_q;

	always_ff @(posedge clk) begin
		if (cmd.take) item_q <= in_item;
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcs_q <= 4'd8;
			stack_cnt_q <= '0; acc_q <= '0; bits_q <= '0; sub_left_q <= '0;
			cw_q <= 4'd9; next_free_q <= CntW'(258); limit_q <= CntW'(512);
			prev_q <= '0; first_q <= '0; have_prev_q <= 1'b0; done_q <= 1'b0;
			code_q <= '0; in_code_q <= '0; kw_q <= 1'b0; walking_q <= 1'b0;
			rpix_q <= '0; rst_q <= ST_ACCEPTED; pop_q <= 1'b0;
		end else begin
			pop_q <= cmd.pop_rd;
			if (cfg_we) mcs_q <= cfg_data;
			if (cmd.dec) begin
				rpix_q <= '0;
				if (item_q.op == OP_PUSH) begin
					if (sub_left_q == '0) begin
						sub_left_q <= item_q.data_byte;
						rst_q <= (item_q.data_byte == '0) ? ST_END_DATA : ST_ACCEPTED;
					end else if (bits_ok) begin
						rst_q <= ST_REJECTED;
					end else begin
						acc_q <= (acc_q | (20'(item_q.data_byte) << bits_q));
						bits_q <= bits_q + 5'd8;
						sub_left_q <= sub_left_q - 8'd1;
						rst_q <= ST_ACCEPTED;
					end
				end else if (item_q.op == OP_RESTART) begin
					stack_cnt_q <= '0; acc_q <= '0; bits_q <= '0; sub_left_q <= '0;
					prev_q <= '0; first_q <= '0; done_q <= 1'b0; have_prev_q <= 1'b0;
					cw_q <= m_eff + 4'd1;
					next_free_q <= clear_c + CntW'(2);
					limit_q <= clear_c << 1;
					rst_q <= ST_RESTARTED;
				end else if (item_q.op != OP_PULL) begin
					rst_q <= ST_REJECTED;
				end else if (stack_cnt_q != '0) begin
					rst_q <= ST_PIXEL;
				end else if (done_q) begin
					rst_q <= ST_END_IMAGE;
				end else if (!bits_ok) begin
					rst_q <= ST_NEED_DATA;
				end else begin
					acc_q <= acc_sh;
					bits_q <= bits_q - {1'b0, cw_q};
					if ({1'b0, code_now} == clear_c) begin
						cw_q <= m_eff + 4'd1;
						next_free_q <= clear_c + CntW'(2);
						limit_q <= clear_c << 1;
						have_prev_q <= 1'b0;
					end else if ({1'b0, code_now} == clear_c + CntW'(1)) begin
						done_q <= 1'b1;
						rst_q <= ST_END_IMAGE;
					end else if (!have_prev_q) begin
						first_q <= code_now[7:0];
						prev_q <= code_now;
						have_prev_q <= 1'b1;
						rpix_q <= code_now[7:0];
						rst_q <= ST_PIXEL;
					end else begin
						in_code_q <= code_now;
						walking_q <= 1'b0;
						if ({1'b0, code_now} >= next_free_q) begin
							kw_q <= 1'b1;
							code_q <= prev_q;
						end else begin
							kw_q <= 1'b0;
							code_q <= code_now;
						end
						rst_q <= ST_PIXEL;
					end
				end
			end
			// chain step: KwKwK push, prime the table read, or push suffix and follow prefix
			if (cmd.walk) begin
				if (kw_q) begin
					stack_cnt_q <= stack_cnt_q + CntW'(1);
					kw_q <= 1'b0;
				end else if (walking_q) begin
					stack_cnt_q <= stack_cnt_q + CntW'(1);
					code_q <= pre_rd;
					walking_q <= cur_more && stk_room2;
				end else begin
					walking_q <= 1'b1;
				end
			end
			// root reached: push, add entry, grow width
			if (cmd.finish) begin
				stack_cnt_q <= stack_cnt_q + CntW'(1);
				first_q <= tbl_root;
				walking_q <= 1'b0;
				prev_q <= in_code_q;
				if (next_free_q < CntW'(Depth)) begin
					next_free_q <= next_free_q + CntW'(1);
					if ((next_free_q + CntW'(1) >= limit_q) && (cw_q < 4'(MaxCodeBits))) begin
						cw_q <= cw_q + 4'd1;
						limit_q <= limit_q << 1;
					end
				end
			end
			// pop: the stack read issued now lands next cycle
			if (cmd.pop_rd) begin
				stack_cnt_q <= stack_cnt_q - CntW'(1);
				rst_q <= ST_PIXEL;
			end
		end
	end
endmodule

// File: hw/rtl/gif_lzw_decoder_unit.sv
// Channel   | signals                              | direction
// in        | in_valid, in_stall, in_data          | item into decoder
// out       | out_valid, out_stall, out_data       | result item out
// cfg       | cfg_we, cfg_wdata                    | root size write
// Push, restart, pops and simple pulls are taken, decoded and emitted.
// A pull that needs a chain walk reads one table entry per step walked;
// the KwKwK case adds a step. It then pushes the root, adds the entry,
// pops and emits. Each clear code repeats the decode step.
// Reset is asynchronous; the tables and stack need no clearing.
// A held output stalls the input; one item is in flight at a time.
// Depends on glzw_pkg, glzw_ctrl, glzw_dp, glzw_ram.
module gif_lzw_decoder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  glzw_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output glzw_pkg::out_item_t out_data
);
	import glzw_pkg::*;

	cmd_t      cmd;
	sts_t      sts;
	out_item_t res;
	logic      res_load;
	logic      out_valid_q;
	out_item_t out_q;

	glzw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_full(out_valid_q && out_stall), .sts(sts), .cmd(cmd)
	);

	glzw_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_wdata),
		.in_item(in_data), .cmd(cmd), .sts(sts), .res(res), .res_load(res_load)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (res_load) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_load) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

// File: hw/rtl/glzw_checker.sv
// Port-level checker for the GIF LZW decoder, bound to the top level.
// Depends on glzw_pkg.
module glzw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input glzw_pkg::out_item_t out_data
);
	import glzw_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// pixel only carries data with pixel status
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_PIXEL |-> out_data.pixel == 8'd0)
		else $error("non-pixel result carries data");

	// an accepted item is not followed by another in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("two items accepted back to back");

	// status code in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 3'd7)
		else $error("bad status");
endmodule

bind gif_lzw_decoder_unit glzw_checker u_glzw_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
